/* hw/rtl/odo_pkg.sv */
package odo_pkg;

    // CORDIC gain, converged value, Q1.30.
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam int unsigned ATAN_ENTRIES = 24;

    localparam logic signed [31:0] ANGLE_QUARTER = 32'sd1073741824;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DIST_PER_COUNT    = 2'd0;
    localparam logic [1:0] CFG_HEADING_PER_COUNT = 2'd1;
    localparam logic [1:0] CFG_UPDATE_RATE       = 2'd2;

    localparam logic [23:0] DIST_PER_COUNT_RST    = 24'd3277;
    localparam logic [23:0] HEADING_PER_COUNT_RST = 24'd445000;
    localparam logic [23:0] UPDATE_RATE_RST       = 24'd12800;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_ACC,
        ST_POST,
        ST_MID,
        ST_ANG,
        ST_ROT,
        ST_SC,
        ST_HALF,
        ST_QUAT,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_S,
        OP_P,
        OP_XLO,
        OP_XHI,
        OP_YLO,
        OP_YHI,
        OP_LLO,
        OP_LHI,
        OP_TLO,
        OP_THI
    } t_op;

    typedef struct packed {
        logic        initial_res;
        logic [63:0] stamp_out;
        logic [31:0] turn_rate;
        logic [31:0] linear_speed;
        logic [15:0] quat_w;
        logic [15:0] quat_z;
        logic [15:0] heading;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } t_result;

    // Arc tangent of 2^-i as a binary angle, 2^31 = pi.
    function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10680862;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/odo_cordic.sv */
module odo_cordic #(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_angle,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    localparam int IW = $clog2(STEPS);
    localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic [IW-1:0]      r_i;
    logic               r_run;
    logic               r_done;

    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] at;

    always_comb begin
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = odo_pkg::atan_entry(5'(r_i));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_i   <= '0;
            end else if (r_run) begin
                r_i <= r_i + 1'b1;
                if (r_i == LAST) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One micro-rotation per cycle; the sign of the residual angle picks the direction.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= odo_pkg::CORDIC_GAIN;
            r_y <= '0;
            r_z <= i_angle;
        end else if (r_run) begin
            if (!r_z[31]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_x;
    assign o_sin  = r_y;

endmodule

/* hw/rtl/differential_drive_odometry.sv */
// Differential-drive wheel odometry with midpoint-heading integration.
// Input stream: one transaction carries the absolute left and right encoder
// counts and a time stamp. Output stream: one transaction per input with the
// pose (x, y, heading), the yaw quaternion, linear speed and turn rate, and the
// time stamp; tuser is high for the first transaction after reset, which only
// latches the counts and reports the identity pose.
// The block takes one transaction at a time. A regular transaction passes
// through the prepare, multiply and rotate states before its result is loaded;
// the first after reset goes straight to the final load. s_axis_tready returns
// the cycle after the result is loaded. The time is spent in one shared 33x32-bit
// multiplier, used ten times for partial products, and one CORDIC rotator run
// twice (midpoint heading, then half heading), one micro-rotation per cycle.
// A result waits in the output register while the receiver stalls; a new
// transaction is still taken and computed, and it is held back only at the
// final load until the previous result has gone.
// Reset (synchronous, active low) clears the pose, the latched counts and the
// output valid, and restores the configuration registers to their defaults.
// Configuration writes take effect at once and are meant for idle periods.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_count [31:0], right_count [63:32], time_stamp [127:64]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x [31:0], pos_y [63:32], heading [79:64], quat_z [95:80],
    // quat_w [111:96], linear_speed [143:112], turn_rate [175:144],
    // stamp_out [239:176]
    output logic [239:0] m_axis_tdata,
    // initial_res [0]
    output logic         m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data
);

    localparam int PROD_W = 65;
    localparam int ACC_W  = PROD_W + 32;

    odo_pkg::t_state r_state, n_state;
    odo_pkg::t_op    r_op, n_op;

    logic               r_pass;
    logic               r_started;
    logic               r_first;
    logic [31:0]        r_prev_l;
    logic [31:0]        r_prev_r;
    logic [31:0]        r_dl;
    logic [31:0]        r_dr;
    logic [32:0]        r_sum_mag;
    logic               r_sum_neg;
    logic [31:0]        r_dif_mag;
    logic               r_dif_neg;
    logic [56:0]        r_dist_mag;
    logic [55:0]        r_turn_mag;
    logic [31:0]        r_mid;
    logic               r_flip;
    logic [31:0]        r_cos_mag;
    logic [31:0]        r_sin_mag;
    logic               r_cos_neg;
    logic               r_sin_neg;
    logic [31:0]        r_x_acc;
    logic [31:0]        r_y_acc;
    logic [31:0]        r_head;
    logic [15:0]        r_quat_z;
    logic [15:0]        r_quat_w;
    logic [31:0]        r_lin;
    logic [31:0]        r_turn;
    logic [63:0]        r_stamp;
    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   r_acc;
    logic [23:0]        r_dist;
    logic [23:0]        r_hpc;
    logic [23:0]        r_rate;
    odo_pkg::t_result   r_out;
    logic               r_out_valid;

    logic               s_accept;
    logic               out_load;
    logic               cordic_start;
    logic signed [31:0] cordic_angle;
    logic               cordic_done;
    logic signed [31:0] cordic_cos;
    logic signed [31:0] cordic_sin;

    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic               op_first;
    logic               op_hi;
    logic [ACC_W-1:0]   acc_next;
    logic               acc_ovf;
    logic [24:0]        xy_q;
    logic               xy_neg;
    logic [31:0]        xy_base;
    logic [33:0]        xy_sum;
    logic [31:0]        xy_new;
    logic               spd_big;
    logic [30:0]        spd_q;
    logic               spd_neg;
    logic [31:0]        spd_new;
    logic [32:0]        p_low;
    logic               mid_flip;
    logic signed [31:0] half_angle;
    odo_pkg::t_result   res_next;

    function automatic logic [31:0] sat34(input logic [33:0] v);
        logic [31:0] r;
        if (!v[33] && (v[32:31] != 2'b00)) begin
            r = odo_pkg::S32_MAX;
        end else if (v[33] && (v[32:31] != 2'b11)) begin
            r = odo_pkg::S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Round half up to Q1.14 and clamp to plus or minus one.
    function automatic logic [15:0] to_q14(input logic signed [31:0] v);
        logic signed [32:0] t;
        logic signed [16:0] r;
        logic [15:0]        q;
        t = {v[31], v} + 33'sd32768;
        r = t[32:16];
        if (r > 17'sd16384) begin
            q = odo_pkg::Q14_ONE;
        end else if (r < -17'sd16384) begin
            q = -odo_pkg::Q14_ONE;
        end else begin
            q = r[15:0];
        end
        return q;
    endfunction

    odo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (cordic_angle),
        .o_done  (cordic_done),
        .o_cos   (cordic_cos),
        .o_sin   (cordic_sin)
    );

    assign s_axis_tready = (r_state == odo_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.initial_res;
    assign m_axis_tdata  = {r_out.stamp_out, r_out.turn_rate, r_out.linear_speed,
                            r_out.quat_w, r_out.quat_z, r_out.heading,
                            r_out.pos_y, r_out.pos_x};

    // Operand selection for the shared multiplier; wide magnitudes are split
    // into a low 32-bit part and a high part weighted by 2^32.
    always_comb begin
        op_first = 1'b0;
        op_hi    = 1'b0;
        unique case (r_op)
            odo_pkg::OP_S: begin
                mul_a = r_sum_mag;
                mul_b = {8'd0, r_dist};
                op_first = 1'b1;
            end
            odo_pkg::OP_P: begin
                mul_a = {1'b0, r_dif_mag};
                mul_b = {8'd0, r_hpc};
                op_first = 1'b1;
            end
            odo_pkg::OP_XLO: begin
                mul_a = {1'b0, r_dist_mag[31:0]};
                mul_b = r_cos_mag;
                op_first = 1'b1;
            end
            odo_pkg::OP_XHI: begin
                mul_a = 33'(r_dist_mag[56:32]);
                mul_b = r_cos_mag;
                op_hi = 1'b1;
            end
            odo_pkg::OP_YLO: begin
                mul_a = {1'b0, r_dist_mag[31:0]};
                mul_b = r_sin_mag;
                op_first = 1'b1;
            end
            odo_pkg::OP_YHI: begin
                mul_a = 33'(r_dist_mag[56:32]);
                mul_b = r_sin_mag;
                op_hi = 1'b1;
            end
            odo_pkg::OP_LLO: begin
                mul_a = {1'b0, r_dist_mag[31:0]};
                mul_b = {8'd0, r_rate};
                op_first = 1'b1;
            end
            odo_pkg::OP_LHI: begin
                mul_a = 33'(r_dist_mag[56:32]);
                mul_b = {8'd0, r_rate};
                op_hi = 1'b1;
            end
            odo_pkg::OP_TLO: begin
                mul_a = {1'b0, r_turn_mag[31:0]};
                mul_b = {8'd0, r_rate};
                op_first = 1'b1;
            end
            odo_pkg::OP_THI: begin
                mul_a = 33'(r_turn_mag[55:32]);
                mul_b = {8'd0, r_rate};
                op_hi = 1'b1;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        acc_next = (op_first ? '0 : r_acc)
                 + (op_hi ? {r_prod, 32'd0} : ACC_W'(r_prod));
    end

    // Post-processing of a finished product.
    always_comb begin
        acc_ovf = |r_acc[ACC_W-1:64];
        xy_q    = r_acc[63:39];
        if (r_op == odo_pkg::OP_XHI) begin
            xy_neg  = r_sum_neg ^ r_cos_neg;
            xy_base = r_x_acc;
        end else begin
            xy_neg  = r_sum_neg ^ r_sin_neg;
            xy_base = r_y_acc;
        end
        xy_sum = xy_neg ? ({{2{xy_base[31]}}, xy_base} - {9'd0, xy_q})
                        : ({{2{xy_base[31]}}, xy_base} + {9'd0, xy_q});
        if (acc_ovf) begin
            xy_new = xy_neg ? odo_pkg::S32_MIN : odo_pkg::S32_MAX;
        end else begin
            xy_new = sat34(xy_sum);
        end

        if (r_op == odo_pkg::OP_LHI) begin
            spd_big = |r_acc[ACC_W-1:48];
            spd_q   = r_acc[47:17];
            spd_neg = r_sum_neg;
        end else begin
            spd_big = |r_acc[ACC_W-1:47];
            spd_q   = r_acc[46:16];
            spd_neg = r_dif_neg;
        end
        if (spd_big) begin
            spd_new = spd_neg ? odo_pkg::S32_MIN : odo_pkg::S32_MAX;
        end else begin
            spd_new = spd_neg ? (32'd0 - {1'b0, spd_q}) : {1'b0, spd_q};
        end

        // Low bits of the signed heading change; bits 32:1 are floor(P/2).
        p_low    = r_dif_neg ? (33'd0 - r_turn_mag[32:0]) : r_turn_mag[32:0];
        mid_flip = ($signed(r_mid) > odo_pkg::ANGLE_QUARTER)
                || ($signed(r_mid) < -odo_pkg::ANGLE_QUARTER);
        // A heading of exactly -pi is taken as +pi for the quaternion.
        if (r_head == odo_pkg::S32_MIN) begin
            half_angle = odo_pkg::ANGLE_QUARTER;
        end else begin
            half_angle = $signed(r_head) >>> 1;
        end
    end

    always_comb begin
        if (r_first) begin
            res_next = '{initial_res: 1'b1, stamp_out: r_stamp, turn_rate: '0,
                         linear_speed: '0, quat_w: odo_pkg::Q14_ONE, quat_z: '0,
                         heading: '0, pos_y: '0, pos_x: '0};
        end else begin
            res_next = '{initial_res: 1'b0, stamp_out: r_stamp, turn_rate: r_turn,
                         linear_speed: r_lin, quat_w: r_quat_w, quat_z: r_quat_z,
                         heading: r_head[31:16], pos_y: r_y_acc, pos_x: r_x_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= odo_pkg::ST_IDLE;
            r_op    <= odo_pkg::OP_S;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        out_load     = 1'b0;
        cordic_start = 1'b0;
        cordic_angle = $signed(r_mid);
        unique case (r_state)
            odo_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_state = r_started ? odo_pkg::ST_PREP : odo_pkg::ST_DONE;
                end
            end
            odo_pkg::ST_PREP: begin
                n_op    = odo_pkg::OP_S;
                n_state = odo_pkg::ST_MUL;
            end
            odo_pkg::ST_MUL: begin
                n_state = odo_pkg::ST_ACC;
            end
            odo_pkg::ST_ACC: begin
                priority case (r_op)
                    odo_pkg::OP_XLO: begin
                        n_op = odo_pkg::OP_XHI;
                        n_state = odo_pkg::ST_MUL;
                    end
                    odo_pkg::OP_YLO: begin
                        n_op = odo_pkg::OP_YHI;
                        n_state = odo_pkg::ST_MUL;
                    end
                    odo_pkg::OP_LLO: begin
                        n_op = odo_pkg::OP_LHI;
                        n_state = odo_pkg::ST_MUL;
                    end
                    odo_pkg::OP_TLO: begin
                        n_op = odo_pkg::OP_THI;
                        n_state = odo_pkg::ST_MUL;
                    end
                    default: begin
                        n_state = odo_pkg::ST_POST;
                    end
                endcase
            end
            odo_pkg::ST_POST: begin
                priority case (r_op)
                    odo_pkg::OP_S: begin
                        n_op = odo_pkg::OP_P;
                        n_state = odo_pkg::ST_MUL;
                    end
                    odo_pkg::OP_XHI: begin
                        n_op = odo_pkg::OP_YLO;
                        n_state = odo_pkg::ST_MUL;
                    end
                    odo_pkg::OP_YHI: begin
                        n_state = odo_pkg::ST_HALF;
                    end
                    odo_pkg::OP_LHI: begin
                        n_op = odo_pkg::OP_TLO;
                        n_state = odo_pkg::ST_MUL;
                    end
                    odo_pkg::OP_THI: begin
                        n_state = odo_pkg::ST_DONE;
                    end
                    default: begin
                        n_state = odo_pkg::ST_MID;
                    end
                endcase
            end
            odo_pkg::ST_MID: begin
                n_state = odo_pkg::ST_ANG;
            end
            odo_pkg::ST_ANG: begin
                // Angles beyond a quarter turn are rotated by a half turn first.
                cordic_start = 1'b1;
                cordic_angle = mid_flip ? $signed({~r_mid[31], r_mid[30:0]})
                                        : $signed(r_mid);
                n_state = odo_pkg::ST_ROT;
            end
            odo_pkg::ST_ROT: begin
                if (cordic_done) begin
                    n_state = r_pass ? odo_pkg::ST_QUAT : odo_pkg::ST_SC;
                end
            end
            odo_pkg::ST_SC: begin
                n_op    = odo_pkg::OP_XLO;
                n_state = odo_pkg::ST_MUL;
            end
            odo_pkg::ST_HALF: begin
                cordic_start = 1'b1;
                cordic_angle = half_angle;
                n_state = odo_pkg::ST_ROT;
            end
            odo_pkg::ST_QUAT: begin
                n_op    = odo_pkg::OP_LLO;
                n_state = odo_pkg::ST_MUL;
            end
            odo_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state = odo_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = odo_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_x_acc     <= '0;
            r_y_acc     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
            r_pass      <= 1'b0;
            r_dist      <= odo_pkg::DIST_PER_COUNT_RST;
            r_hpc       <= odo_pkg::HEADING_PER_COUNT_RST;
            r_rate      <= odo_pkg::UPDATE_RATE_RST;
        end else begin
            if (i_cfg_we) begin
                priority case (i_cfg_index)
                    odo_pkg::CFG_DIST_PER_COUNT:    r_dist <= i_cfg_data;
                    odo_pkg::CFG_HEADING_PER_COUNT: r_hpc  <= i_cfg_data;
                    odo_pkg::CFG_UPDATE_RATE:       r_rate <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_accept) begin
                r_started <= 1'b1;
                r_prev_l  <= s_axis_tdata[31:0];
                r_prev_r  <= s_axis_tdata[63:32];
            end
            if (r_state == odo_pkg::ST_MID) begin
                r_head <= r_head + p_low[31:0];
            end
            if (r_state == odo_pkg::ST_ANG) begin
                r_pass <= 1'b0;
            end else if (r_state == odo_pkg::ST_HALF) begin
                r_pass <= 1'b1;
            end
            if (r_state == odo_pkg::ST_POST && r_op == odo_pkg::OP_XHI) begin
                r_x_acc <= xy_new;
            end
            if (r_state == odo_pkg::ST_POST && r_op == odo_pkg::OP_YHI) begin
                r_y_acc <= xy_new;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_first <= !r_started;
            r_stamp <= s_axis_tdata[127:64];
            r_dl    <= s_axis_tdata[31:0] - r_prev_l;
            r_dr    <= s_axis_tdata[63:32] - r_prev_r;
        end
        unique case (r_state)
            odo_pkg::ST_PREP: begin
                logic [32:0] sum;
                logic [32:0] dif;
                sum = {r_dl[31], r_dl} + {r_dr[31], r_dr};
                dif = {r_dr[31], r_dr} - {r_dl[31], r_dl};
                r_sum_neg <= sum[32];
                r_sum_mag <= sum[32] ? (33'd0 - sum) : sum;
                r_dif_neg <= dif[32];
                r_dif_mag <= dif[32] ? 32'(33'd0 - dif) : dif[31:0];
            end
            odo_pkg::ST_MUL: begin
                r_prod <= mul_a * {1'b0, mul_b};
            end
            odo_pkg::ST_ACC: begin
                r_acc <= acc_next;
            end
            odo_pkg::ST_POST: begin
                priority case (r_op)
                    odo_pkg::OP_S: r_dist_mag <= r_acc[56:0];
                    odo_pkg::OP_P: r_turn_mag <= r_acc[55:0];
                    odo_pkg::OP_LHI: r_lin <= spd_new;
                    odo_pkg::OP_THI: r_turn <= spd_new;
                    default: ;
                endcase
            end
            odo_pkg::ST_MID: begin
                r_mid <= r_head + p_low[32:1];
            end
            odo_pkg::ST_ANG: begin
                r_flip <= mid_flip;
            end
            odo_pkg::ST_SC: begin
                r_cos_mag <= cordic_cos[31] ? (32'd0 - cordic_cos) : cordic_cos;
                r_sin_mag <= cordic_sin[31] ? (32'd0 - cordic_sin) : cordic_sin;
                r_cos_neg <= r_flip ? (cordic_cos > 32'sd0) : cordic_cos[31];
                r_sin_neg <= r_flip ? (cordic_sin > 32'sd0) : cordic_sin[31];
            end
            odo_pkg::ST_QUAT: begin
                r_quat_z <= to_q14(cordic_sin);
                r_quat_w <= to_q14(cordic_cos);
            end
            default: ;
        endcase
        if (out_load) begin
            r_out <= res_next;
        end
    end

endmodule

/* hw/rtl/odo_checker.sv */
module odo_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [239:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // Out of reset the block is empty and ready for a transaction.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not empty after reset");

    // Only one transaction is computed at a time, so the input closes after each one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open after an accepted transaction");

    // The result that only latches counts carries a zero pose and the identity.
    a_initial_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[95:0] == 96'd0 && m_axis_tdata[111:96] == 16'd16384
            && m_axis_tdata[175:112] == 64'd0)
        else $error("initial result is not the identity pose");

    // The quaternion stays within plus or minus one in Q1.14.
    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[95:80]) <= 16'sd16384
            && $signed(m_axis_tdata[95:80]) >= -16'sd16384
            && $signed(m_axis_tdata[111:96]) <= 16'sd16384
            && $signed(m_axis_tdata[111:96]) >= -16'sd16384)
        else $error("quaternion component out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind differential_drive_odometry odo_checker u_odo_checker (.*);

/* tb/sv/tb_differential_drive_odometry.sv */
module tb_differential_drive_odometry;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROT_STEPS = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 100;
    localparam longint GAIN = odo_pkg::CORDIC_GAIN;
    localparam longint ANGLE_Q = odo_pkg::ANGLE_QUARTER;
    localparam longint HALF_TURN = 64'sd1 << 31;
    localparam longint STEP_LIM = 64'sd1 << 40;
    localparam logic [23:0] REG_MAX = 24'hFF_FFFF;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [239:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = odo_pkg::CFG_DIST_PER_COUNT;
    logic [23:0]  i_cfg_data = '0;

    // Arc tangents of 2^-i as binary angles, 2^31 = pi.
    longint arctan_tab [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    // Predictor copy of the configuration and the odometry state.
    logic [23:0]        cfg_dist = odo_pkg::DIST_PER_COUNT_RST;
    logic [23:0]        cfg_yaw = odo_pkg::HEADING_PER_COUNT_RST;
    logic [23:0]        cfg_rate = odo_pkg::UPDATE_RATE_RST;
    logic [31:0]        last_left = '0;
    logic [31:0]        last_right = '0;
    bit                 begun = 1'b0;
    logic signed [31:0] pos_x_acc = '0;
    logic signed [31:0] pos_y_acc = '0;
    logic [31:0]        yaw_acc = '0;

    odo_pkg::t_result pose_expected [$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    bit          gaps_on = 1'b1;
    logic [31:0] cur_left = '0;
    logic [31:0] cur_right = '0;
    logic [63:0] ts_now = '0;

    differential_drive_odometry #(
        .CORDIC_STEPS(ROT_STEPS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void cordic_rotate(input longint ang, output longint c,
                                          output longint s);
        longint x, y, z, dx, dy;
        x = GAIN;
        y = 0;
        z = ang;
        for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_tab[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_tab[i];
            end
        end
        c = x;
        s = y;
    endfunction

    // Angles beyond a quarter turn are rotated by half a turn first.
    function automatic void sincos_any(input logic [31:0] a, output longint c,
                                       output longint s);
        longint v;
        logic [31:0] b;
        logic flip;
        v = $signed(a);
        flip = (v > ANGLE_Q) || (v < -ANGLE_Q);
        if (flip) begin
            b = a + 32'h8000_0000;
            v = $signed(b);
        end
        cordic_rotate(v, c, s);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endfunction

    // Truncated v * r / 2^sh; a product beyond 64 bits or a magnitude above
    // lim is clamped to lim.
    function automatic longint scale_sat(input longint v, input longint r, input int sh,
                                         input longint lim);
        logic [127:0] mag, prod, q;
        mag = (v < 0) ? -v : v;
        prod = mag * r;
        if (prod > 128'hFFFF_FFFF_FFFF_FFFF)
            q = lim;
        else
            q = prod >> sh;
        if (q > lim)
            q = lim;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -HALF_TURN)
            return -HALF_TURN;
        return v;
    endfunction

    function automatic logic [15:0] to_q14(input longint v);
        longint t;
        t = (v + 64'sd32768) >>> 16;
        if (t > 16384)
            t = 16384;
        if (t < -16384)
            t = -16384;
        return t[15:0];
    endfunction

    function automatic odo_pkg::t_result predict_pose(input logic [31:0] l,
                                                      input logic [31:0] r,
                                                      input logic [63:0] ts);
        odo_pkg::t_result res;
        logic [31:0] dl_raw, dr_raw, mid;
        longint dl, dr, dpc, hpc, rate, travel, turn_p, half, c, s, step, acc;
        res = '0;
        res.stamp_out = ts;
        if (!begun) begin
            last_left = l;
            last_right = r;
            begun = 1'b1;
            res.initial_res = 1'b1;
            res.quat_w = odo_pkg::Q14_ONE;
            return res;
        end
        dl_raw = l - last_left;
        dr_raw = r - last_right;
        dl = $signed(dl_raw);
        dr = $signed(dr_raw);
        last_left = l;
        last_right = r;
        dpc = cfg_dist;
        hpc = cfg_yaw;
        rate = cfg_rate;
        travel = (dl + dr) * dpc;
        turn_p = (dr - dl) * hpc;

        // Position advances along the heading at the middle of the step.
        half = turn_p >>> 1;
        mid = yaw_acc + half[31:0];
        sincos_any(mid, c, s);
        step = scale_sat(travel, (c < 0) ? -c : c, 39, STEP_LIM);
        if (c < 0)
            step = -step;
        acc = pos_x_acc;
        acc = clamp32(acc + step);
        pos_x_acc = acc[31:0];
        step = scale_sat(travel, (s < 0) ? -s : s, 39, STEP_LIM);
        if (s < 0)
            step = -step;
        acc = pos_y_acc;
        acc = clamp32(acc + step);
        pos_y_acc = acc[31:0];
        yaw_acc = yaw_acc + turn_p[31:0];

        // A heading of exactly minus pi is taken as plus pi for the quaternion.
        acc = $signed(yaw_acc);
        half = (acc == -HALF_TURN) ? ANGLE_Q : (acc >>> 1);
        cordic_rotate(half, c, s);

        res.pos_x = pos_x_acc;
        res.pos_y = pos_y_acc;
        res.heading = yaw_acc[31:16];
        res.quat_z = to_q14(s);
        res.quat_w = to_q14(c);
        acc = clamp32(scale_sat(travel, rate, 17, HALF_TURN));
        res.linear_speed = acc[31:0];
        acc = clamp32(scale_sat(turn_p, rate, 16, HALF_TURN));
        res.turn_rate = acc[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("[%0t] pose mismatch on %s: got %h, expected %h", $realtime, what, got,
                 want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic check_pose(input logic [239:0] data, input logic user);
        odo_pkg::t_result got, want;
        got.pos_x = data[31:0];
        got.pos_y = data[63:32];
        got.heading = data[79:64];
        got.quat_z = data[95:80];
        got.quat_w = data[111:96];
        got.linear_speed = data[143:112];
        got.turn_rate = data[175:144];
        got.stamp_out = data[239:176];
        got.initial_res = user;
        if (pose_expected.size() == 0) begin
            report_mismatch("result with nothing pending", got.stamp_out, '0);
            return;
        end
        want = pose_expected.pop_front();
        check_field("initial_res", got.initial_res, want.initial_res);
        check_field("pos_x", got.pos_x, want.pos_x);
        check_field("pos_y", got.pos_y, want.pos_y);
        check_field("heading", got.heading, want.heading);
        check_field("quat_z", got.quat_z, want.quat_z);
        check_field("quat_w", got.quat_w, want.quat_w);
        check_field("linear_speed", got.linear_speed, want.linear_speed);
        check_field("turn_rate", got.turn_rate, want.turn_rate);
        check_field("stamp_out", got.stamp_out, want.stamp_out);
    endtask

    // Receiver: checks each transaction and stalls at random or on request.
    always @(posedge i_clk) begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready)
            check_pose(m_axis_tdata, m_axis_tuser);
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 32);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_sample(input logic [31:0] l, input logic [31:0] r,
                               input logic [63:0] ts);
        while (gaps_on && $urandom_range(0, 99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ts, r, l};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        pose_expected.push_back(predict_pose(l, r, ts));
    endtask

    task automatic send_step(input logic [31:0] dl, input logic [31:0] dr);
        cur_left = cur_left + dl;
        cur_right = cur_right + dr;
        ts_now = ts_now + $urandom_range(1, 50000);
        send_sample(cur_left, cur_right, ts_now);
    endtask

    // Mostly plausible wheel motion, with the odd wild jump or fresh count pair.
    task automatic send_random_sample();
        int unsigned pick, span;
        logic [31:0] common;
        pick = $urandom_range(0, 99);
        if (pick < 94) begin
            case ($urandom_range(0, 2))
                0: span = 16;
                1: span = 2000;
                default: span = 200000;
            endcase
            common = $urandom_range(0, 2 * span) - span;
            cur_left = cur_left + common + $urandom_range(0, span / 4) - span / 8;
            cur_right = cur_right + common + $urandom_range(0, span / 4) - span / 8;
        end else if (pick < 97) begin
            cur_left = cur_left + $urandom;
            cur_right = cur_right + $urandom;
        end else begin
            cur_left = $urandom;
            cur_right = $urandom;
        end
        if ($urandom_range(0, 49) == 0)
            ts_now = {$urandom, $urandom};
        else
            ts_now = ts_now + $urandom_range(1, 50000);
        send_sample(cur_left, cur_right, ts_now);
    endtask

    // Always waits on a clock edge, so back-to-back calls never drive
    // the valid twice in one step.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pose_expected.size() != 0);
    endtask

    task automatic apply_setting(input logic [23:0] dpc_val, input logic [23:0] yaw,
                                 input logic [23:0] rate);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= odo_pkg::CFG_DIST_PER_COUNT;
        i_cfg_data <= dpc_val;
        @(posedge i_clk);
        i_cfg_index <= odo_pkg::CFG_HEADING_PER_COUNT;
        i_cfg_data <= yaw;
        @(posedge i_clk);
        i_cfg_index <= odo_pkg::CFG_UPDATE_RATE;
        i_cfg_data <= rate;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_dist = dpc_val;
        cfg_yaw = yaw;
        cfg_rate = rate;
    endtask

    // With 2^23 per count difference, 256 counts make exactly half a turn.
    task automatic test_half_turn_heading();
        apply_setting(odo_pkg::DIST_PER_COUNT_RST, 24'h80_0000, odo_pkg::UPDATE_RATE_RST);
        cur_left = 32'h8000_0000;
        cur_right = 32'h7FFF_FFFF;
        ts_now = '1;
        send_sample(cur_left, cur_right, ts_now);
        send_step(0, 256);
        send_step(0, 256);
        send_step(64, -64);
        send_step(0, 0);
    endtask

    task automatic test_saturation_extremes();
        apply_setting(REG_MAX, REG_MAX, REG_MAX);
        send_step(32'h8000_0000, 32'h7FFF_FFFF);
        send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_step(32'h8000_0000, 32'h8000_0000);
        send_step(0, 0);
        apply_setting(24'd1, 24'd1, 24'd1);
        send_step(1, 1);
        send_step(-1, 1);
        send_step(1, -1);
        send_step(0, 0);
        // A zero rate gives zero speeds.
        apply_setting(odo_pkg::DIST_PER_COUNT_RST, odo_pkg::HEADING_PER_COUNT_RST, 24'd0);
        send_step(100, 300);
        send_step(-5, 7);
    endtask

    task automatic test_setting_sweep();
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: apply_setting(odo_pkg::DIST_PER_COUNT_RST, odo_pkg::HEADING_PER_COUNT_RST,
                                 odo_pkg::UPDATE_RATE_RST);
                1: apply_setting(24'd1, REG_MAX, 24'd1);
                2: apply_setting(REG_MAX, 24'd1, REG_MAX);
                default: apply_setting(24'($urandom_range(1, REG_MAX)),
                                       24'($urandom_range(1, REG_MAX)),
                                       24'($urandom_range(1, REG_MAX)));
            endcase
            repeat (60) send_random_sample();
        end
    endtask

    task automatic test_no_gaps();
        apply_setting(odo_pkg::DIST_PER_COUNT_RST, odo_pkg::HEADING_PER_COUNT_RST,
                      odo_pkg::UPDATE_RATE_RST);
        gaps_on = 1'b0;
        repeat (200) send_random_sample();
        gaps_on = 1'b1;
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_receiver_hold();
        apply_setting(odo_pkg::DIST_PER_COUNT_RST, odo_pkg::HEADING_PER_COUNT_RST,
                      odo_pkg::UPDATE_RATE_RST);
        hold_request = 400;
        repeat (12) send_random_sample();
    endtask

    task automatic test_random_stream();
        apply_setting(24'($urandom_range(1, 8000)), 24'($urandom_range(1, 1000000)),
                      24'($urandom_range(1, 100000)));
        repeat (700) send_random_sample();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_half_turn_heading();
        test_saturation_extremes();
        test_setting_sweep();
        test_no_gaps();
        test_receiver_hold();
        test_random_stream();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
